>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

>>> rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Constants, control word layout and microcode ROM of the median detector.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int VALUE_BITS = 8;
    localparam int BIN_COUNT  = 1 << VALUE_BITS;
    localparam int WINDOW_MAX = 1024;
    localparam int PTR_BITS   = $clog2(WINDOW_MAX);
    localparam int COUNT_BITS = PTR_BITS + 1;
    localparam int TWICE_BITS = VALUE_BITS + 1;
    localparam int CNT_BITS   = VALUE_BITS + 1;
    localparam int WS_RESET   = 5;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PTR_BITS-1:0]   ptr_t;
    typedef logic [3:0]            step_t;

    // program addresses
    localparam step_t STEP_FETCH  = 4'd0;
    localparam step_t STEP_CHECK  = 4'd1;
    localparam step_t STEP_WALK   = 4'd2;
    localparam step_t STEP_RING   = 4'd3;
    localparam step_t STEP_OLD_RD = 4'd4;
    localparam step_t STEP_OLD_WR = 4'd5;
    localparam step_t STEP_NEW_RD = 4'd6;
    localparam step_t STEP_NEW_WR = 4'd7;
    localparam step_t STEP_EMIT   = 4'd8;

    typedef enum logic [1:0] {
        HRD_NONE = 2'd0,
        HRD_BIN  = 2'd1,
        HRD_OLD  = 2'd2,
        HRD_NEW  = 2'd3
    } hrd_t;

    typedef enum logic [1:0] {
        HWR_NONE = 2'd0,
        HWR_DEC  = 2'd1,
        HWR_INC  = 2'd2
    } hwr_t;

    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_NO_IN    = 3'd1,
        C_NOT_FULL = 3'd2,
        C_CNT_LEFT = 3'd3,
        C_OUT_BUSY = 3'd4
    } cond_t;

    typedef struct packed {
        hrd_t  hrd;
        hwr_t  hwr;
        logic  ring_rd;
        logic  ring_wr;
        logic  take_in;
        logic  acc;
        logic  cnt_inc;
        logic  emit;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } ctl_t;

    // microcode ROM: jump to jmp when cond holds, else go to nxt
    function automatic ctl_t ucode(input step_t pc);
        ctl_t w;
        w = '{hrd: HRD_NONE, hwr: HWR_NONE, ring_rd: 1'b0, ring_wr: 1'b0,
              take_in: 1'b0, acc: 1'b0, cnt_inc: 1'b0, emit: 1'b0,
              cond: C_ALWAYS, jmp: STEP_FETCH, nxt: STEP_FETCH};
        case (pc)
            STEP_FETCH:
            begin
                w.take_in = 1'b1;
                w.cond    = C_NO_IN;
                w.jmp     = STEP_FETCH;
                w.nxt     = STEP_CHECK;
            end
            STEP_CHECK:
            begin
                w.cond = C_NOT_FULL;
                w.jmp  = STEP_NEW_RD;
                w.nxt  = STEP_WALK;
            end
            STEP_WALK:
            begin
                w.hrd     = HRD_BIN;
                w.acc     = 1'b1;
                w.cnt_inc = 1'b1;
                w.cond    = C_CNT_LEFT;
                w.jmp     = STEP_WALK;
                w.nxt     = STEP_RING;
            end
            STEP_RING:
            begin
                w.ring_rd = 1'b1;
                w.cond    = C_ALWAYS;
                w.jmp     = STEP_OLD_RD;
            end
            STEP_OLD_RD:
            begin
                w.hrd  = HRD_OLD;
                w.cond = C_ALWAYS;
                w.jmp  = STEP_OLD_WR;
            end
            STEP_OLD_WR:
            begin
                w.hwr  = HWR_DEC;
                w.cond = C_ALWAYS;
                w.jmp  = STEP_NEW_RD;
            end
            STEP_NEW_RD:
            begin
                w.hrd  = HRD_NEW;
                w.cond = C_ALWAYS;
                w.jmp  = STEP_NEW_WR;
            end
            STEP_NEW_WR:
            begin
                w.hwr     = HWR_INC;
                w.ring_wr = 1'b1;
                w.cond    = C_ALWAYS;
                w.jmp     = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = C_OUT_BUSY;
                w.jmp  = STEP_EMIT;
                w.nxt  = STEP_FETCH;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.jmp  = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/trailing_median_spike_detector.sv
// ----------------------------------------------------------------------------
// trailing_median_spike_detector
// Sliding-window median by counting histogram, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/amount) takes one sample word at a time.
//   Output channel (out_valid/out_ready) returns one result word per sample:
//   checked, notify and median_twice (lower plus upper median).
//   Config channel (cfg_valid/cfg_ready/window_size) sets the window length;
//   0 reads as 1, values above 1024 read as 1024. A write restarts the window.
// Timing:
//   A full-window sample runs the steps fetch, check, walk, ring, old read,
//   old write, new read, new write and emit; one still filling the window
//   skips from check to new read. The walk over the 256 histogram bins, one
//   bin per cycle through the single histogram read port, makes up most of the first.
//   The next sample is taken the cycle after the result is loaded.
// Reset:
//   Window length 5, window empty, histogram counts zero (per-bin valid
//   bits cleared at once, no clearing pass).
// Stall:
//   A result waits in the output register; the sequencer holds at its final
//   step until that register is free, and takes no sample meanwhile.
// ----------------------------------------------------------------------------
module trailing_median_spike_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tms_pkg::VALUE_BITS-1:0]   amount,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             checked,
    output logic                             notify,
    output logic [tms_pkg::TWICE_BITS-1:0]   median_twice,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tms_pkg::COUNT_BITS-1:0]   window_size
);
    import tms_pkg::*;

    // sequencer
    step_t pc_reg, pc_next;
    ctl_t  ctl;
    logic  cond_true;

    // window control
    count_t ws_reg, ws_next;
    count_t seen_reg, seen_next;
    ptr_t   wp_reg, wp_next;
    logic [BIN_COUNT-1:0] hv_reg, hv_next;   // bin count is meaningful

    // walk state
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic   live_reg, live_next;             // bin read issued last cycle
    value_t bin_reg, bin_next;
    count_t cum_reg, cum_next;
    logic   lo_found_reg, lo_found_next;
    logic   hi_found_reg, hi_found_next;
    value_t lo_reg, lo_next;
    value_t hi_reg, hi_next;
    logic   chk_reg, chk_next;
    value_t amt_reg, amt_next;

    // output register
    logic                  ov_reg, ov_next;
    logic                  oc_reg, oc_next;
    logic                  on_reg, on_next;
    logic [TWICE_BITS-1:0] ot_reg, ot_next;

    // memories
    count_t hist_mem [BIN_COUNT];
    value_t ring_mem [WINDOW_MAX];
    count_t hist_q_reg;
    value_t ring_q_reg;

    logic   hrd_en;
    value_t hrd_addr;
    logic   hwr_en;
    value_t hwr_addr;
    count_t hwr_data;
    count_t bin_cnt;
    count_t cur_cnt;
    ptr_t   old_idx;

    logic   in_fire, cfg_fire, out_busy, emit_fire, full;
    count_t lo_rank, hi_rank;
    logic [COUNT_BITS:0] ws_p1;
    logic [TWICE_BITS-1:0] twice;
    count_t cfg_ws;

    assign ctl       = ucode(pc_reg);
    assign cfg_ready = (pc_reg == STEP_FETCH);
    assign in_ready  = (pc_reg == STEP_FETCH) && !cfg_valid;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_busy  = ov_reg && !out_ready;
    assign emit_fire = ctl.emit && !out_busy;
    assign full      = (seen_reg >= ws_reg);

    // median ranks: (d+1)/2 and d/2+1
    assign ws_p1   = {1'b0, ws_reg} + 1'b1;
    assign lo_rank = ws_p1[COUNT_BITS:1];
    assign hi_rank = {1'b0, ws_reg[COUNT_BITS-1:1]} + 1'b1;

    assign old_idx = wp_reg - ws_reg[PTR_BITS-1:0];
    assign twice   = chk_reg ? ({1'b0, lo_reg} + {1'b0, hi_reg}) : '0;

    always_comb
    begin
        if (window_size == '0)
            cfg_ws = count_t'(1);
        else if (window_size > count_t'(WINDOW_MAX))
            cfg_ws = count_t'(WINDOW_MAX);
        else
            cfg_ws = window_size;
    end

    always_comb
    begin
        case (ctl.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_IN:    cond_true = !in_fire;
            C_NOT_FULL: cond_true = !chk_reg;
            C_CNT_LEFT: cond_true = (cnt_reg != CNT_BITS'(BIN_COUNT));
            C_OUT_BUSY: cond_true = out_busy;
            default:    cond_true = 1'b1;
        endcase
        pc_next = cond_true ? ctl.jmp : ctl.nxt;
    end

    // histogram port selection
    always_comb
    begin
        hrd_en   = 1'b0;
        hrd_addr = '0;
        case (ctl.hrd)
            HRD_BIN:
            begin
                hrd_en   = !cnt_reg[CNT_BITS-1];
                hrd_addr = cnt_reg[VALUE_BITS-1:0];
            end
            HRD_OLD:
            begin
                hrd_en   = 1'b1;
                hrd_addr = ring_q_reg;
            end
            HRD_NEW:
            begin
                hrd_en   = 1'b1;
                hrd_addr = amt_reg;
            end
            default:
            begin
                hrd_en   = 1'b0;
                hrd_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        hwr_addr = (ctl.hwr == HWR_DEC) ? ring_q_reg : amt_reg;
        cur_cnt  = hv_reg[hwr_addr] ? hist_q_reg : '0;
        hwr_en   = 1'b0;
        hwr_data = cur_cnt;
        case (ctl.hwr)
            HWR_DEC:
            begin
                hwr_en   = (cur_cnt != '0);
                hwr_data = cur_cnt - 1'b1;
            end
            HWR_INC:
            begin
                hwr_en   = 1'b1;
                hwr_data = cur_cnt + 1'b1;
            end
            default:
            begin
                hwr_en   = 1'b0;
                hwr_data = cur_cnt;
            end
        endcase
    end

    assign bin_cnt = hv_reg[bin_reg] ? hist_q_reg : '0;

    always_comb
    begin
        ws_next       = ws_reg;
        seen_next     = seen_reg;
        wp_next       = wp_reg;
        hv_next       = hv_reg;
        cnt_next      = cnt_reg;
        live_next     = 1'b0;
        bin_next      = bin_reg;
        cum_next      = cum_reg;
        lo_found_next = lo_found_reg;
        hi_found_next = hi_found_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        chk_next      = chk_reg;
        amt_next      = amt_reg;
        ov_next       = ov_reg;
        oc_next       = oc_reg;
        on_next       = on_reg;
        ot_next       = ot_reg;

        if (cfg_fire)
        begin
            ws_next   = cfg_ws;
            seen_next = '0;
            wp_next   = '0;
            hv_next   = '0;
        end

        if (ctl.take_in && in_fire)
        begin
            amt_next      = amount[VALUE_BITS-1:0];
            chk_next      = full;
            cnt_next      = '0;
            cum_next      = '0;
            lo_found_next = 1'b0;
            hi_found_next = 1'b0;
            lo_next       = '1;
            hi_next       = '1;
        end

        if (ctl.hrd == HRD_BIN)
        begin
            live_next = hrd_en;
            bin_next  = hrd_addr;
        end
        if (ctl.cnt_inc)
            cnt_next = cnt_reg + 1'b1;

        // cumulative count against both ranks, one bin per cycle
        if (ctl.acc && live_reg)
        begin
            cum_next = cum_reg + bin_cnt;
            if (!lo_found_reg && (cum_next >= lo_rank))
            begin
                lo_found_next = 1'b1;
                lo_next       = bin_reg;
            end
            if (!hi_found_reg && (cum_next >= hi_rank))
            begin
                hi_found_next = 1'b1;
                hi_next       = bin_reg;
            end
        end

        if (ctl.hwr == HWR_INC)
            hv_next[amt_reg] = 1'b1;

        if (ctl.ring_wr)
        begin
            wp_next = wp_reg + 1'b1;
            if (!full)
                seen_next = seen_reg + 1'b1;
        end

        if (out_ready)
            ov_next = 1'b0;
        if (emit_fire)
        begin
            ov_next = 1'b1;
            oc_next = chk_reg;
            on_next = chk_reg && ({1'b0, amt_reg} >= twice);
            ot_next = twice;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= STEP_FETCH;
            ws_reg       <= count_t'(WS_RESET);
            seen_reg     <= '0;
            wp_reg       <= '0;
            hv_reg       <= '0;
            cnt_reg      <= '0;
            live_reg     <= 1'b0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
            chk_reg      <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            ws_reg       <= ws_next;
            seen_reg     <= seen_next;
            wp_reg       <= wp_next;
            hv_reg       <= hv_next;
            cnt_reg      <= cnt_next;
            live_reg     <= live_next;
            lo_found_reg <= lo_found_next;
            hi_found_reg <= hi_found_next;
            chk_reg      <= chk_next;
            ov_reg       <= ov_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        cum_reg <= cum_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        amt_reg <= amt_next;
        oc_reg  <= oc_next;
        on_reg  <= on_next;
        ot_reg  <= ot_next;
    end

    // histogram memory, registered read
    always_ff @(posedge clk)
    begin
        if (hwr_en)
            hist_mem[hwr_addr] <= hwr_data;
        if (hrd_en)
            hist_q_reg <= hist_mem[hrd_addr];
    end

    // sample ring, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.ring_wr)
            ring_mem[wp_reg] <= amt_reg;
        if (ctl.ring_rd)
            ring_q_reg <= ring_mem[old_idx];
    end

    assign out_valid    = ov_reg;
    assign checked      = oc_reg;
    assign notify       = on_reg;
    assign median_twice = ot_reg;

endmodule

>>> rtl/tms_checker.sv
// ----------------------------------------------------------------------------
// tms_checker
// Port-level checks of the median detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tms_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           checked,
    input  logic                           notify,
    input  logic [tms_pkg::TWICE_BITS-1:0] median_twice,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready
);
    import tms_pkg::*;

    logic [TWICE_BITS-1:0] mt;
    assign mt = median_twice;

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mt))
    // unchecked word carries no median and no flag
    `ASSERT_SAME(a_unchecked, clk, rst_n, out_valid && !checked, mt == '0 && !notify)
    // flag only on a checked word
    `ASSERT_SAME(a_notify_chk, clk, rst_n, out_valid && notify, checked)
    // one sample at a time: busy right after an accept
    `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    // config write and sample accept never share an edge
    `ASSERT_SAME(a_cfg_excl, clk, rst_n, cfg_valid && cfg_ready, !(in_valid && in_ready))

endmodule

bind trailing_median_spike_detector tms_checker u_tms_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trailing median spike detector. A behavioral
// histogram model predicts every result word; samples are streamed through
// valid/ready with random idling on both sides, across several window
// lengths including the clamped extremes; the full-ring run wraps the slot.
// ----------------------------------------------------------------------------
module testbench;

    import tms_pkg::*;

    // one expected result word, field for field as on the output ports
    typedef struct packed {
        logic                  checked;
        logic                  notify;
        logic [TWICE_BITS-1:0] median_twice;
    } spike_verdict_t;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    // thresholds on the accepted-word count that switch the idling profile
    localparam int SWAP_IDLE_AT   = 500;
    localparam int NO_IDLE_AT     = 1000;
    // one long receiver hold-off so the block backs up into its input
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 3000;
    // drain time after the last result, leaving room for a stray full-window word
    localparam int DRAIN_CYCLES   = 400;
    localparam longint LIMIT_NS   = 64'd40_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    value_t                amount = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  checked;
    logic                  notify;
    logic [TWICE_BITS-1:0] median_twice;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    count_t                window_size = '0;

    // stimulus and scoreboard storage
    value_t                sample_queue [$];
    count_t                window_writes [$];
    spike_verdict_t        verdict_queue [$];
    int                    accepted_count = 0;
    int                    window_writes_done = 0;
    int                    mismatch_count = 0;
    int                    holdoff_left = 0;
    logic                  holdoff_done = 1'b0;

    // model state: histogram, sample ring, write slot, fill level, window
    count_t                bin_tally [BIN_COUNT];
    value_t                ring_copy [WINDOW_MAX];
    ptr_t                  write_slot;
    count_t                fill_level;
    count_t                window_len;

    // directed opening, run with the reset window of 5:
    //  - extremes 0 / 255 while filling (unchecked)
    //  - a window of ones then a sample exactly twice the median (flag on
    //    equality) and one just below
    //  - an all-255 window giving the largest median_twice
    value_t directed_samples [22] = '{
        8'd0, 8'd255, 8'd0, 8'd255, 8'd128,
        8'd255, 8'd0,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd2, 8'd1, 8'd3,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0
    };

    trailing_median_spike_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .amount       (amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .checked      (checked),
        .notify       (notify),
        .median_twice (median_twice),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_size  (window_size)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // window restart: empty histogram, slot and fill level back to zero
    function automatic void clear_window();
        foreach (bin_tally[b])
            bin_tally[b] = '0;
        write_slot = '0;
        fill_level = '0;
    endfunction

    // smallest value whose running count reaches rank
    function automatic value_t value_at_rank(int rank);
        int cum;
        cum = 0;
        for (int b = 0; b < BIN_COUNT; b++)
        begin
            cum += bin_tally[b];
            if (cum >= rank)
                return value_t'(b);
        end
        return '1;
    endfunction

    // median check for one sample, then slide the window
    function automatic spike_verdict_t predict_spike_verdict(value_t sample);
        spike_verdict_t verdict;
        value_t         lower_med;
        value_t         upper_med;
        value_t         leaving;
        ptr_t           oldest_slot;
        verdict = '0;
        if (fill_level >= window_len)
        begin
            lower_med = value_at_rank((int'(window_len) + 1) / 2);
            upper_med = value_at_rank(int'(window_len) / 2 + 1);
            verdict.checked      = 1'b1;
            verdict.median_twice = {1'b0, lower_med} + {1'b0, upper_med};
            verdict.notify       = ({1'b0, sample} >= verdict.median_twice);
            // ring slot of the oldest sample; a 1024 window wraps onto itself
            oldest_slot = write_slot - ptr_t'(window_len);
            leaving     = ring_copy[oldest_slot];
            if (bin_tally[leaving] != '0)
                bin_tally[leaving] = bin_tally[leaving] - 1'b1;
        end
        ring_copy[write_slot] = sample;
        bin_tally[sample]     = bin_tally[sample] + 1'b1;
        write_slot            = write_slot + 1'b1;
        if (fill_level < window_len)
            fill_level = fill_level + 1'b1;
        return verdict;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("MISMATCH t=%0t word %0d: %s got %0d want %0d",
                 $realtime, accepted_count, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Configuration driver: one window_size word at a time from
    // window_writes; the model restarts its window on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid   <= 1'b0;
            window_size <= '0;
            clear_window();
            window_len = count_t'(WS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            // 0 reads as 1, anything past the ring size as the ring size
            if (window_size == '0)
                window_len = count_t'(1);
            else if (window_size > WINDOW_MAX)
                window_len = count_t'(WINDOW_MAX);
            else
                window_len = window_size;
            clear_window();
            window_writes_done++;
            cfg_valid <= 1'b0;
        end
        else if (!cfg_valid && window_writes.size() != 0)
        begin
            cfg_valid   <= 1'b1;
            window_size <= window_writes.pop_front();
        end
    end

    // ------------------------------------------------------------------------
    // Sample driver: predicts each accepted word, then offers the next one
    // unless this cycle is an idle one
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        int             sender_pct;
        spike_verdict_t fresh;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            amount   <= '0;
        end
        else
        begin
            sender_pct = (accepted_count < SWAP_IDLE_AT) ? 14 :
                         (accepted_count < NO_IDLE_AT)   ? 56 : 0;
            if (in_valid && in_ready)
            begin
                fresh         = predict_spike_verdict(amount);
                verdict_queue = {verdict_queue, fresh};
                accepted_count++;
            end
            // slot is free when nothing was offered or the offer just went in
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= sender_pct)
                begin
                    in_valid <= 1'b1;
                    amount   <= sample_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off, fired once mid-run; the sender keeps offering,
    // so the output register fills and in_ready drops
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (!holdoff_done && accepted_count >= HOLDOFF_AT)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every accepted word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        spike_verdict_t due;
        int             receiver_pct;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            receiver_pct = (accepted_count < SWAP_IDLE_AT) ? 56 :
                           (accepted_count < NO_IDLE_AT)   ? 14 : 0;
            if (out_valid && out_ready)
            begin
                if (verdict_queue.size() == 0)
                    report_mismatch("unexpected result word, checked", checked, 0);
                else
                begin
                    due = verdict_queue.pop_front();
                    if (checked !== due.checked)
                        report_mismatch("checked", checked, due.checked);
                    if (notify !== due.notify)
                        report_mismatch("notify", notify, due.notify);
                    if (median_twice !== due.median_twice)
                        report_mismatch("median_twice", median_twice, due.median_twice);
                end
            end
            out_ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= receiver_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------------

    // block until every queued sample went in and every result came back
    task automatic wait_drained();
        while (sample_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
            @(posedge clk);
    endtask

    // window_size is only written with the block idle
    task automatic write_window(count_t code);
        int target;
        wait_drained();
        target = window_writes_done + 1;
        window_writes = {window_writes, code};
        while (window_writes_done != target)
            @(posedge clk);
    endtask

    // random samples around a baseline level: mostly near it, some spikes
    // (a few exactly twice the level), some full-range and rail values
    task automatic queue_random_samples(int count);
        int level;
        int pick;
        int v;
        level = $urandom_range(4, 100);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                v = 0;
            else if (pick < 10)
                v = 255;
            else if (pick < 25)
                v = $urandom_range(0, 255);
            else if (pick < 80)
                v = level - 4 + $urandom_range(0, 8);
            else if (pick < 88)
                v = 2 * level;
            else
                v = 2 * level - 3 + $urandom_range(0, 40);
            if (v > 255)
                v = 255;
            sample_queue = {sample_queue, value_t'(v)};
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening with the reset window length
        foreach (directed_samples[i])
            sample_queue = {sample_queue, directed_samples[i]};

        // zero clamps to a window of one
        write_window(11'd0);
        queue_random_samples(20);

        // even window: lower and upper median differ
        write_window(11'd2);
        queue_random_samples(20);

        // odd window
        write_window(11'd3);
        queue_random_samples(20);

        write_window(11'($urandom_range(4, 12)));
        queue_random_samples(30);

        // all ones clamps to the full 1024 ring: fill it, then a few checks
        // while the write slot wraps
        write_window(11'h7FF);
        queue_random_samples(WINDOW_MAX + 16);

        wait_drained();
        // a block that emits extra words would show them here
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && verdict_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop for a hung handshake
    initial
    begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
